### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define CHK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_SAME(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/tced_pkg.sv
// ---------------------------------------------------------------------------
// tced_pkg
// Types, constants and search functions of the two-car elevator dispatcher.
// ---------------------------------------------------------------------------
`default_nettype none

package tced_pkg;

   // number of served floors; mask bits at or above it are ignored
   localparam int FLOORS = 8;
   localparam logic [7:0] FLOOR_MASK = (FLOORS >= 8) ? 8'hFF : 8'((1 << FLOORS) - 1);

   // car motion codes
   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   typedef struct packed {
      logic [7:0] hall_calls;
      logic [7:0] car_a_calls;
      logic [7:0] car_b_calls;
      logic [2:0] floor_a;
      logic [1:0] dir_a;
      logic [2:0] floor_b;
      logic [1:0] dir_b;
   } req_type;

   typedef struct packed {
      logic [2:0] dest_a;
      logic [2:0] dest_b;
   } rsp_type;

   // result of one mask search
   typedef struct packed {
      logic       found;
      logic [2:0] pos;
   } pick_type;

   function automatic logic [2:0] floor_gap(input logic [2:0] a, input logic [2:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // search a button mask by the direction rules
   function automatic pick_type pick_floor(input logic [7:0] mask,
                                           input logic [2:0] here,
                                           input logic [1:0] dir);
      pick_type   res;
      logic [7:0] m;
      logic [2:0] best_gap;
      logic [2:0] fl;
      res      = '0;
      m        = mask & FLOOR_MASK;
      best_gap = '0;
      case (dir)
         DIR_UP: begin
            // lowest pressed floor at or above the car
            for (int i = 0; i < 8; i++) begin
               fl = 3'(i);
               if (!res.found && fl >= here && m[fl]) begin
                  res.found = 1'b1;
                  res.pos   = fl;
               end
            end
         end
         DIR_DOWN: begin
            // highest pressed floor at or below the car
            for (int i = 7; i >= 0; i--) begin
               fl = 3'(i);
               if (!res.found && fl <= here && m[fl]) begin
                  res.found = 1'b1;
                  res.pos   = fl;
               end
            end
         end
         DIR_IDLE: begin
            // nearest pressed floor, tie to the lower floor
            for (int i = 0; i < 8; i++) begin
               fl = 3'(i);
               if (m[fl] && (!res.found || floor_gap(fl, here) < best_gap)) begin
                  res.found = 1'b1;
                  res.pos   = fl;
                  best_gap  = floor_gap(fl, here);
               end
            end
         end
         default: begin
            res = '0;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/two_car_elevator_dispatch_top.sv
// ---------------------------------------------------------------------------
// two_car_elevator_dispatch_top
// Next destination floor for each of two cars from call masks and positions.
// ---------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall / req_data) carries the three
//   call masks with each car's floor and direction. A request transfers at a
//   rising edge with req_valid high and req_stall low.
//   The response channel (rsp_valid / rsp_stall / rsp_data) returns dest_a
//   and dest_b, one response per request, in request order.
//   A transferred request passes through the input register, then the dispatch
//   logic into the result register, which drives rsp_valid and rsp_data.
//   Throughput is one request per cycle while rsp_stall is low; the result
//   register advances whenever empty or its content transfers in the same cycle.
//   While rsp_stall holds a full result register, the input register still
//   takes one request; req_stall rises only when both registers are full.
//   Synchronous reset empties both registers; there is no other state.
// ---------------------------------------------------------------------------
`default_nettype none

module two_car_elevator_dispatch_top
   import tced_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_ready;
   logic    req_xfer;
   logic    s1_move;
   rsp_type result;

   pick_type own_a, own_b, hall_a, hall_b;
   logic     bid_a, bid_b;
   logic [2:0] gap_a, gap_b;

   // handshake control
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;
   assign req_xfer  = req_valid && !req_stall;
   assign s1_move   = s1_valid_ff && out_ready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !out_ready);
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture request and result payloads
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= result;
      end
   end

   // panel and hall searches for both cars
   always_comb begin
      own_a  = pick_floor(s1_data_ff.car_a_calls, s1_data_ff.floor_a, s1_data_ff.dir_a);
      own_b  = pick_floor(s1_data_ff.car_b_calls, s1_data_ff.floor_b, s1_data_ff.dir_b);
      hall_a = pick_floor(s1_data_ff.hall_calls, s1_data_ff.floor_a, s1_data_ff.dir_a);
      hall_b = pick_floor(s1_data_ff.hall_calls, s1_data_ff.floor_b, s1_data_ff.dir_b);
      bid_a  = !own_a.found && hall_a.found;
      bid_b  = !own_b.found && hall_b.found;
      gap_a  = floor_gap(hall_a.pos, s1_data_ff.floor_a);
      gap_b  = floor_gap(hall_b.pos, s1_data_ff.floor_b);
   end

   // settle the hall bids
   always_comb begin
      result.dest_a = own_a.found ? own_a.pos : s1_data_ff.floor_a;
      result.dest_b = own_b.found ? own_b.pos : s1_data_ff.floor_b;
      if (bid_a && (!bid_b || gap_a < gap_b)) begin
         result.dest_a = hall_a.pos;
         if (bid_b && hall_a.pos != hall_b.pos) begin
            result.dest_b = hall_b.pos;
         end
      end else if (bid_b && (!bid_a || gap_b < gap_a)) begin
         result.dest_b = hall_b.pos;
         if (bid_a && hall_a.pos != hall_b.pos) begin
            result.dest_a = hall_a.pos;
         end
      end else if (bid_a && bid_b) begin
         if (hall_a.pos == hall_b.pos) begin
            // same floor at equal distance: a moving car B takes it
            if (s1_data_ff.dir_b != DIR_IDLE) begin
               result.dest_b = hall_b.pos;
            end else begin
               result.dest_a = hall_a.pos;
            end
         end else begin
            result.dest_a = hall_a.pos;
            result.dest_b = hall_b.pos;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
`include "assert_macros.svh"
   `CHK_NEXT(a_req_lands, clock, reset, req_xfer, s1_valid_ff)
   `CHK_NEXT(a_result_loads, clock, reset, s1_move, rsp_valid_ff && rsp_data_ff == $past(result))
   `CHK_NEXT(a_empty_drains, clock, reset, !s1_valid_ff && out_ready, !rsp_valid_ff)
   `CHK_SAME(a_stall_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)

endmodule

`default_nettype wire
